@@ rtl/core/satlb_pkg.sv @@
// satlb_pkg: shared types and constants for the set-associative TLB.
// No dependencies.
`timescale 1ns / 1ps
package satlb_pkg;
    localparam int PAGE_W  = 27;
    localparam int FRAME_W = 44;
    localparam int PTE_W   = 64;

    typedef enum logic [1:0] {
        KIND_LOOKUP    = 2'd0,
        KIND_REFILL    = 2'd1,
        KIND_SHOOTDOWN = 2'd2,
        KIND_FLUSH     = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic capture;
        logic exec;
        logic flush;
    } t_cmd;
endpackage

@@ rtl/core/set_assoc_tlb_lru.sv @@
// Set-associative TLB with true LRU per set; top level.
// Depends on satlb_pkg, satlb_ctrl, satlb_dp.
// One request at a time. Refill and shootdown step through accept with memory read,
// a wait state, and compare and update; a lookup then adds a state in which its result
// is offered, held there until taken; flush completes when it is accepted.
// Set = page_number mod SETS (SETS a power of two); tag = upper bits.
`timescale 1ns / 1ps
module set_assoc_tlb_lru #(
    parameter int SETS = 64,
    parameter int WAYS = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [1:0]                      i_kind,
    input  logic [satlb_pkg::PAGE_W-1:0]    i_page_number,
    input  logic [satlb_pkg::FRAME_W-1:0]   i_fill_frame,
    input  logic [satlb_pkg::PTE_W-1:0]     i_fill_entry,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_hit,
    output logic [satlb_pkg::FRAME_W-1:0]   o_frame,
    output logic [satlb_pkg::PTE_W-1:0]     o_table_entry
);
    import satlb_pkg::*;

    t_cmd  cmd;
    t_kind kind;
    assign kind = t_kind'(i_kind);

    satlb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_kind  (kind),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd)
    );

    satlb_dp #(.SETS(SETS), .WAYS(WAYS)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_kind        (kind),
        .i_page_number (i_page_number),
        .i_fill_frame  (i_fill_frame),
        .i_fill_entry  (i_fill_entry),
        .o_hit         (o_hit),
        .o_frame       (o_frame),
        .o_table_entry (o_table_entry)
    );
endmodule

@@ rtl/core/satlb_ctrl.sv @@
// satlb_ctrl: request sequencing state machine.
// Depends on satlb_pkg.
`timescale 1ns / 1ps
module satlb_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  satlb_pkg::t_kind     i_kind,
    output logic                 o_valid,
    input  logic                 i_ready,
    output satlb_pkg::t_cmd      o_cmd
);
    import satlb_pkg::*;

    t_state r_state, n_state;
    t_kind  r_kind, n_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_kind  <= KIND_LOOKUP;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        o_ready = 1'b0;
        o_valid = 1'b0;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_kind = i_kind;
                    if (i_kind == KIND_FLUSH) begin
                        o_cmd.flush = 1'b1;
                    end else begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: begin
                n_state = ST_EXEC;
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state = (r_kind == KIND_LOOKUP) ? ST_OUT : ST_IDLE;
            end
            ST_OUT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

@@ rtl/core/satlb_dp.sv @@
// satlb_dp: tag/data memories, valid and rank flops, hit and LRU logic.
// Depends on satlb_pkg.
`timescale 1ns / 1ps
module satlb_dp #(
    parameter int SETS = 64,
    parameter int WAYS = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  satlb_pkg::t_cmd                 i_cmd,
    input  satlb_pkg::t_kind                i_kind,
    input  logic [satlb_pkg::PAGE_W-1:0]    i_page_number,
    input  logic [satlb_pkg::FRAME_W-1:0]   i_fill_frame,
    input  logic [satlb_pkg::PTE_W-1:0]     i_fill_entry,
    output logic                            o_hit,
    output logic [satlb_pkg::FRAME_W-1:0]   o_frame,
    output logic [satlb_pkg::PTE_W-1:0]     o_table_entry
);
    import satlb_pkg::*;

    localparam int SW = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SB = $clog2(SETS);
    localparam int TAG_W = PAGE_W - SB;
    localparam int ENT_W = TAG_W + FRAME_W + PTE_W;

    logic [ENT_W-1:0] mem [WAYS][SETS];
    logic [ENT_W-1:0] r_rd [WAYS];
    logic [SETS-1:0][WAYS-1:0] r_valid;
    logic [SETS-1:0][WAYS-1:0][WW-1:0] r_rank;

    t_kind              r_kind;
    logic [SW-1:0]      r_set;
    logic [TAG_W-1:0]   r_tag;
    logic [FRAME_W-1:0] r_ff;
    logic [PTE_W-1:0]   r_fe;

    logic [SW-1:0] in_set;
    assign in_set = (SETS > 1) ? SW'(i_page_number) : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind <= i_kind;
            r_set  <= in_set;
            r_tag  <= i_page_number[PAGE_W-1 -: TAG_W];
            r_ff   <= i_fill_frame;
            r_fe   <= i_fill_entry;
        end
    end

    logic [WAYS-1:0] match;
    logic            any;
    logic [WW-1:0]   hway, fway, lway, pick;
    logic            has_free;
    logic [WAYS-1:0] vset;

    always_comb begin
        vset = r_valid[r_set];
        match = '0;
        any = 1'b0;
        hway = '0;
        fway = '0;
        has_free = 1'b0;
        lway = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            match[w] = vset[w] && (r_rd[w][ENT_W-1 -: TAG_W] == r_tag);
            if (match[w]) begin
                hway = WW'(w);
                any = 1'b1;
            end
            if (!vset[w]) begin
                fway = WW'(w);
                has_free = 1'b1;
            end
            if (r_rank[r_set][w] == '0) begin
                lway = WW'(w);
            end
        end
        pick = any ? hway : (has_free ? fway : lway);
    end

    logic do_promote;
    logic [WW-1:0] pway;
    assign do_promote = i_cmd.exec && ((r_kind == KIND_LOOKUP && any) ||
                                       r_kind == KIND_REFILL);
    assign pway = (r_kind == KIND_REFILL) ? pick : hway;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            for (int w = 0; w < WAYS; w++) begin
                r_rd[w] <= mem[w][in_set];
            end
        end
        if (i_cmd.exec && r_kind == KIND_REFILL) begin
            for (int w = 0; w < WAYS; w++) begin
                if (pick == WW'(w)) begin
                    mem[w][r_set] <= {r_tag, r_ff, r_fe};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            for (int s = 0; s < SETS; s++) begin
                for (int w = 0; w < WAYS; w++) begin
                    r_rank[s][w] <= WW'(w);
                end
            end
        end else begin
            if (i_cmd.flush) begin
                r_valid <= '0;
            end
            if (i_cmd.exec && r_kind == KIND_REFILL) begin
                r_valid[r_set][pick] <= 1'b1;
            end
            if (i_cmd.exec && r_kind == KIND_SHOOTDOWN && any) begin
                r_valid[r_set][hway] <= 1'b0;
            end
            if (do_promote) begin
                for (int w = 0; w < WAYS; w++) begin
                    if (pway == WW'(w)) begin
                        r_rank[r_set][w] <= WW'(WAYS - 1);
                    end else if (r_rank[r_set][w] > r_rank[r_set][pway]) begin
                        r_rank[r_set][w] <= r_rank[r_set][w] - 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && r_kind == KIND_LOOKUP) begin
            o_hit         <= any;
            o_frame       <= any ? r_rd[hway][PTE_W +: FRAME_W] : '0;
            o_table_entry <= any ? r_rd[hway][PTE_W-1:0] : '0;
        end
    end
endmodule

@@ verif/set_assoc_tlb_lru_chk.sv @@
// set_assoc_tlb_lru_chk: watches the request and result channels of the TLB,
// predicts each lookup result with its own set/LRU state and compares them.
// Depends on satlb_pkg.
`timescale 1ns / 1ps
module set_assoc_tlb_lru_chk
    import satlb_pkg::*;
#(
    parameter int SETS = 64,
    parameter int WAYS = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_ready_in,
    input  logic [1:0]         i_kind,
    input  logic [PAGE_W-1:0]  i_page_number,
    input  logic [FRAME_W-1:0] i_fill_frame,
    input  logic [PTE_W-1:0]   i_fill_entry,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic               i_hit,
    input  logic [FRAME_W-1:0] i_frame,
    input  logic [PTE_W-1:0]   i_table_entry,
    output int                 o_errors,
    output int                 o_pending
);
    localparam int TOTAL = SETS * WAYS;

    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame;
        logic [PTE_W-1:0]   pte;
    } t_lookup;

    logic               tlb_valid [TOTAL];
    logic [PAGE_W-1:0]  tlb_tag   [TOTAL];
    logic [FRAME_W-1:0] tlb_frame [TOTAL];
    logic [PTE_W-1:0]   tlb_pte   [TOTAL];
    int                 tlb_rank  [TOTAL];
    t_lookup            lookups_due[$];

    assign o_pending = lookups_due.size();

    task automatic make_recent(input int base, input int way);
        int old;
        old = tlb_rank[base + way];
        for (int w = 0; w < WAYS; w++)
            if (tlb_rank[base + w] > old) tlb_rank[base + w]--;
        tlb_rank[base + way] = WAYS - 1;
    endtask

    task automatic apply_request(input t_kind kind, input logic [PAGE_W-1:0] page,
                                 input logic [FRAME_W-1:0] fframe,
                                 input logic [PTE_W-1:0] fpte);
        int base, way, pick;
        logic [PAGE_W-1:0] tag;
        t_lookup res;
        base = (page % SETS) * WAYS;
        tag  = PAGE_W'(page / SETS);
        way  = -1;
        if (kind == KIND_FLUSH) begin
            for (int i = 0; i < TOTAL; i++) tlb_valid[i] = 1'b0;
            return;
        end
        for (int w = WAYS - 1; w >= 0; w--)
            if (tlb_valid[base + w] && tlb_tag[base + w] == tag) way = w;
        case (kind)
            KIND_LOOKUP: begin
                res = '0;
                if (way >= 0) begin
                    res.hit   = 1'b1;
                    res.frame = tlb_frame[base + way];
                    res.pte   = tlb_pte[base + way];
                    make_recent(base, way);
                end
                lookups_due = {lookups_due, res};
            end
            KIND_SHOOTDOWN: begin
                if (way >= 0) tlb_valid[base + way] = 1'b0;
            end
            default: begin
                pick = way;
                if (pick < 0)
                    for (int w = WAYS - 1; w >= 0; w--)
                        if (!tlb_valid[base + w]) pick = w;
                if (pick < 0)
                    for (int w = WAYS - 1; w >= 0; w--)
                        if (tlb_rank[base + w] == 0) pick = w;
                tlb_valid[base + pick] = 1'b1;
                tlb_tag[base + pick]   = tag;
                tlb_frame[base + pick] = fframe;
                tlb_pte[base + pick]   = fpte;
                make_recent(base, pick);
            end
        endcase
    endtask

    initial begin
        o_errors = 0;
        for (int i = 0; i < TOTAL; i++) begin
            tlb_valid[i] = 1'b0;
            tlb_rank[i]  = i % WAYS;
        end
    end

    always @(posedge i_clk) begin
        t_lookup want;
        if (i_rst_n && i_out_valid && i_out_ready) begin
            if (lookups_due.size() == 0) begin
                o_errors++;
                if (o_errors <= 10) $display("unexpected lookup result hit=%0b", i_hit);
            end else begin
                want = lookups_due[0];
                lookups_due.delete(0);
                if (want.hit !== i_hit || want.frame !== i_frame
                        || want.pte !== i_table_entry) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display({"mismatch: exp hit=%0b frame=%h pte=%h",
                                  " got hit=%0b frame=%h pte=%h"},
                                 want.hit, want.frame, want.pte, i_hit, i_frame, i_table_entry);
                end
            end
        end
        if (i_rst_n && i_valid && i_ready_in)
            apply_request(t_kind'(i_kind), i_page_number, i_fill_frame, i_fill_entry);
    end
endmodule

@@ verif/set_assoc_tlb_lru_tb.sv @@
// set_assoc_tlb_lru_tb: drives TLB requests with random gaps and back-pressure,
// and reports the verdict from the checker's error count.
// Depends on satlb_pkg, set_assoc_tlb_lru, set_assoc_tlb_lru_chk.
`timescale 1ns / 1ps
module set_assoc_tlb_lru_tb;
    import satlb_pkg::*;

    localparam int SETS = 64;
    localparam int WAYS = 4;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [1:0]         i_kind;
    logic [PAGE_W-1:0]  i_page_number;
    logic [FRAME_W-1:0] i_fill_frame;
    logic [PTE_W-1:0]   i_fill_entry;
    logic               o_valid;
    logic               i_ready;
    logic               o_hit;
    logic [FRAME_W-1:0] o_frame;
    logic [PTE_W-1:0]   o_table_entry;
    int                 errors;
    int                 pending;
    bit                 calm;
    logic [PAGE_W-1:0]  recent_pages[$];

    set_assoc_tlb_lru #(.SETS(SETS), .WAYS(WAYS)) dut (.*);

    set_assoc_tlb_lru_chk #(.SETS(SETS), .WAYS(WAYS)) chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_ready_in(o_ready),
        .i_kind(i_kind), .i_page_number(i_page_number), .i_fill_frame(i_fill_frame),
        .i_fill_entry(i_fill_entry), .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_hit(o_hit), .i_frame(o_frame), .i_table_entry(o_table_entry),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("*** FAILED ***");
        $finish;
    end

    always @(negedge i_clk) begin
        i_ready <= calm ? 1'b1 : ($urandom_range(99) >= 13);
    end

    // called at a falling edge; returns at the falling edge after the accepting edge
    task automatic send_request(input t_kind kind, input logic [PAGE_W-1:0] page,
                                input logic [FRAME_W-1:0] fframe,
                                input logic [PTE_W-1:0] fpte);
        while (!calm && $urandom_range(99) < 13) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_kind        <= kind;
        i_page_number <= page;
        i_fill_frame  <= fframe;
        i_fill_entry  <= fpte;
        while (!o_ready) @(negedge i_clk);
        @(posedge i_clk);
        @(negedge i_clk);
        recent_pages = {recent_pages, page};
        if (recent_pages.size() > 24) recent_pages.delete(0);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    function automatic logic [PAGE_W-1:0] pick_page();
        logic [PAGE_W-1:0] p;
        int r;
        r = $urandom_range(99);
        if (r < 45 && recent_pages.size() > 0)
            p = recent_pages[$urandom_range(recent_pages.size() - 1)];
        else if (r < 80)
            // few sets, many tags: forces evictions
            p = {21'($urandom_range(15)), 6'($urandom_range(3))};
        else
            p = PAGE_W'($urandom);
        return p;
    endfunction

    function automatic logic [FRAME_W-1:0] rand_frame();
        return FRAME_W'({$urandom, $urandom});
    endfunction

    function automatic logic [PTE_W-1:0] rand_pte();
        return {$urandom, $urandom};
    endfunction

    initial begin
        logic [PAGE_W-1:0] p;
        int r;
        t_kind k;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_ready       = 1'b0;
        i_kind        = KIND_LOOKUP;
        i_page_number = '0;
        i_fill_frame  = '0;
        i_fill_entry  = '0;
        calm          = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: misses, extremes, fill a set past capacity, update, shootdown, flush
        send_request(KIND_LOOKUP, '0, '0, '0);
        send_request(KIND_REFILL, '0, '0, '0);
        send_request(KIND_REFILL, '1, '1, '1);
        send_request(KIND_LOOKUP, '0, '0, '0);
        send_request(KIND_LOOKUP, '1, '0, '0);
        for (int t = 1; t <= 5; t++)
            send_request(KIND_REFILL, PAGE_W'(t * SETS + 5), FRAME_W'(t), PTE_W'(t));
        send_request(KIND_LOOKUP, PAGE_W'(SETS + 5), '0, '0);
        send_request(KIND_REFILL, PAGE_W'(2 * SETS + 5), 44'hA5A5A5A5A5A, 64'h5A5A5A5A5A5A5A5A);
        send_request(KIND_LOOKUP, PAGE_W'(2 * SETS + 5), '0, '0);
        send_request(KIND_SHOOTDOWN, PAGE_W'(3 * SETS + 5), '0, '0);
        send_request(KIND_SHOOTDOWN, PAGE_W'(9 * SETS + 5), '0, '0);
        send_request(KIND_LOOKUP, PAGE_W'(3 * SETS + 5), '0, '0);
        send_request(KIND_REFILL, PAGE_W'(7 * SETS + 5), '1, '0);
        send_request(KIND_FLUSH, '0, '0, '0);
        send_request(KIND_LOOKUP, '1, '0, '0);
        send_request(KIND_LOOKUP, PAGE_W'(2 * SETS + 5), '0, '0);

        // hold off until all results have drained
        drain();

        for (int n = 0; n < 850; n++) begin
            calm = (n >= 300 && n < 400);
            r = $urandom_range(99);
            if (r < 45)      k = KIND_LOOKUP;
            else if (r < 85) k = KIND_REFILL;
            else if (r < 98) k = KIND_SHOOTDOWN;
            else             k = KIND_FLUSH;
            p = pick_page();
            send_request(k, p, rand_frame(), rand_pte());
            if (n == 600)
                drain();
        end
        calm = 1'b0;

        drain();
        repeat (20) @(negedge i_clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

@@ files.f @@
rtl/core/satlb_pkg.sv
rtl/core/satlb_ctrl.sv
rtl/core/satlb_dp.sv
rtl/core/set_assoc_tlb_lru.sv
verif/set_assoc_tlb_lru_chk.sv
verif/set_assoc_tlb_lru_tb.sv
